/* hdl/bss_pkg.sv */
`timescale 1ns / 1ps

package bss_pkg;

  // largest needle and width of the haystack byte counter
  localparam int unsigned MaxNeedle  = 64;
  localparam int unsigned OffsetBits = 32;

  localparam int unsigned LenW    = $clog2(MaxNeedle + 1);
  localparam int unsigned ByteW   = 8;
  localparam int unsigned PosW    = 32;
  localparam int unsigned Symbols = 1 << ByteW;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_APPEND  = 2'd1,
    OP_HAY     = 2'd2,
    OP_RESTART = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_FOUND    = 2'd0,
    ST_NUL      = 2'd1,
    ST_LIMIT    = 2'd2,
    ST_TOO_LONG = 2'd3
  } status_e;

  // update of the per-symbol position masks, issued as a beat leaves the match stage
  typedef struct packed {
    logic                 step;
    logic                 clear;
    logic                 we;
    logic [ByteW-1:0]     addr;
    logic [MaxNeedle-1:0] data;
  } mask_wr_t;

endpackage

/* hdl/bss_mask_mem.sv */
`timescale 1ns / 1ps

module bss_mask_mem import bss_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 rd_en_i,
  input  logic [ByteW-1:0]     rd_addr_i,
  input  logic [ByteW-1:0]     s1_addr_i,
  input  mask_wr_t             wr_i,
  output logic [MaxNeedle-1:0] mask_o
);

  logic [MaxNeedle-1:0] mem [Symbols];
  logic [MaxNeedle-1:0] rdata_q;
  logic [Symbols-1:0]   valid_q;
  logic                 fwd_valid_q;
  logic [ByteW-1:0]     fwd_addr_q;
  logic [MaxNeedle-1:0] fwd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rdata_q <= mem[rd_addr_i];
    end
  end

  // valid bits stand in for clearing the table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      fwd_valid_q <= 1'b0;
    end else begin
      if (wr_i.clear) begin
        valid_q <= '0;
      end else if (wr_i.we) begin
        valid_q[wr_i.addr] <= 1'b1;
      end
      if (wr_i.step) begin
        fwd_valid_q <= wr_i.we;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.step) begin
      fwd_addr_q <= wr_i.addr;
      fwd_data_q <= wr_i.data;
    end
  end

  // previous beat's write may have raced this beat's read
  always_comb begin
    if (fwd_valid_q && (fwd_addr_q == s1_addr_i)) begin
      mask_o = fwd_data_q;
    end else if (valid_q[s1_addr_i]) begin
      mask_o = rdata_q;
    end else begin
      mask_o = '0;
    end
  end

endmodule

/* hdl/bss_matcher.sv */
`timescale 1ns / 1ps

module bss_matcher import bss_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s1_valid_i,
  input  opcode_e              s1_op_i,
  input  logic [ByteW-1:0]     s1_byte_i,
  input  logic                 s1_last_i,
  input  logic [MaxNeedle-1:0] mask_i,
  input  logic                 advance_i,
  output mask_wr_t             wr_o,
  output logic                 res_valid_o,
  output status_e              res_status_o,
  output logic [PosW-1:0]      res_pos_o
);

  logic [LenW-1:0]       len_q, len_d;
  logic                  ovf_q, ovf_d;
  logic [MaxNeedle-1:0]  pmv_q, pmv_d;
  logic [OffsetBits-1:0] off_q, off_d;
  logic                  done_q, done_d;

  logic                  step;
  logic [MaxNeedle-1:0]  pmv_next;
  logic                  hit;
  logic [OffsetBits-1:0] pos_full;

  assign step     = s1_valid_i && advance_i;
  assign pmv_next = ((pmv_q << 1) | MaxNeedle'(1)) & mask_i;
  assign hit      = |(pmv_next & (MaxNeedle'(1) << (len_q - LenW'(1))));
  assign pos_full = off_q + OffsetBits'(1) - OffsetBits'(len_q);

  always_comb begin
    len_d        = len_q;
    ovf_d        = ovf_q;
    pmv_d        = pmv_q;
    off_d        = off_q;
    done_d       = done_q;
    res_valid_o  = 1'b0;
    res_status_o = ST_FOUND;
    res_pos_o    = '0;
    wr_o.step    = step;
    wr_o.clear   = 1'b0;
    wr_o.we      = 1'b0;
    wr_o.addr    = s1_byte_i;
    wr_o.data    = mask_i | (MaxNeedle'(1) << len_q);

    case (s1_op_i)
      OP_CLEAR: begin
        len_d      = '0;
        ovf_d      = 1'b0;
        pmv_d      = '0;
        off_d      = '0;
        done_d     = 1'b0;
        wr_o.clear = step;
      end
      OP_APPEND: begin
        pmv_d  = '0;
        off_d  = '0;
        done_d = 1'b0;
        if (s1_byte_i != '0) begin
          if (len_q < LenW'(MaxNeedle)) begin
            wr_o.we = step;
            len_d   = len_q + LenW'(1);
          end else begin
            ovf_d = 1'b1;
          end
        end
      end
      OP_HAY: begin
        if (!done_q) begin
          if (ovf_q) begin
            res_valid_o  = 1'b1;
            res_status_o = ST_TOO_LONG;
          end else if (len_q == '0) begin
            res_valid_o  = 1'b1;
            res_status_o = ST_FOUND;
          end else if (s1_byte_i == '0) begin
            res_valid_o  = 1'b1;
            res_status_o = ST_NUL;
          end else begin
            pmv_d = pmv_next;
            if (hit) begin
              res_valid_o  = 1'b1;
              res_status_o = ST_FOUND;
              res_pos_o    = PosW'(pos_full);
            end else if (s1_last_i) begin
              res_valid_o  = 1'b1;
              res_status_o = ST_LIMIT;
            end else begin
              off_d = off_q + OffsetBits'(1);
            end
          end
          if (res_valid_o) begin
            done_d = 1'b1;
          end
        end
      end
      OP_RESTART: begin
        pmv_d  = '0;
        off_d  = '0;
        done_d = 1'b0;
      end
      default: begin
        done_d = done_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      ovf_q  <= 1'b0;
      pmv_q  <= '0;
      off_q  <= '0;
      done_q <= 1'b0;
    end else if (step) begin
      len_q  <= len_d;
      ovf_q  <= ovf_d;
      pmv_q  <= pmv_d;
      off_q  <= off_d;
      done_q <= done_d;
    end
  end

endmodule

/* hdl/bounded_substring_search.sv */
`timescale 1ns / 1ps
// bounded substring search, shift-and matcher
// input channel (in_valid_i / in_ready_o) carries one command beat: clear needle,
// append a needle byte, a haystack byte, or restart the search
// output channel (out_valid_o / out_ready_i) carries at most one result beat
// per search: found with its start offset, nul reached, limit reached or
// needle too long; after it, haystack beats are dropped until a restart, clear or append
// throughput: one beat per cycle, any mix of commands, unless a held result stalls a beat;
// set by the single read-modify-write pass over the 256-entry symbol mask memory
// path: a beat registers into the match stage together with its mask memory read when
// it is accepted, and its result then registers into the output register
// when the receiver stalls, the held result blocks a beat that would make
// another result, and the beats behind it; all other beats keep flowing
// reset: control state clears at once; the mask memory holds garbage but
// per-symbol valid bits mask it, so no clearing pass is needed and the
// block accepts beats as soon as reset is released
module bounded_substring_search import bss_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        opcode_i,
  input  logic [ByteW-1:0]  data_byte_i,
  input  logic              limit_last_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        status_o,
  output logic [PosW-1:0]   match_position_o
);

  // match stage: beat waiting on its mask memory read
  logic             s1_valid_q;
  opcode_e          s1_op_q;
  logic [ByteW-1:0] s1_byte_q;
  logic             s1_last_q;

  logic                 accept;
  logic                 advance;
  logic [MaxNeedle-1:0] mask;
  mask_wr_t             wr;
  logic                 res_valid;
  status_e              res_status;
  logic [PosW-1:0]      res_pos;

  logic             out_valid_q;
  logic [1:0]       status_q;
  logic [PosW-1:0]  pos_q;

  // stage leaves unless it holds a result and the output register is full and not being drained
  assign advance    = !res_valid || !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || advance;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q   <= opcode_e'(opcode_i);
      s1_byte_q <= data_byte_i;
      s1_last_q <= limit_last_i;
    end
  end

  // every beat reads the mask of its byte; only haystack and append use it
  bss_mask_mem u_mask_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (data_byte_i),
    .s1_addr_i (s1_byte_q),
    .wr_i      (wr),
    .mask_o    (mask)
  );

  bss_matcher u_matcher (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s1_valid_i   (s1_valid_q),
    .s1_op_i      (s1_op_q),
    .s1_byte_i    (s1_byte_q),
    .s1_last_i    (s1_last_q),
    .mask_i       (mask),
    .advance_i    (advance),
    .wr_o         (wr),
    .res_valid_o  (res_valid),
    .res_status_o (res_status),
    .res_pos_o    (res_pos)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_valid_q && advance && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && advance && res_valid) begin
      status_q <= res_status;
      pos_q    <= res_pos;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign match_position_o = pos_q;

endmodule
